// File: design/e2q_pkg.sv
// Shared types, constants and the arctangent table for the Euler-to-quaternion block.
`default_nettype none
package e2q_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int QUAT_WIDTH  = 16;

  // Internal Q.30 datapath
  localparam int FRAC    = 30;
  localparam int STEPS   = 30;
  localparam int CW      = 34;              // CORDIC x/y/z width
  localparam int SC_W    = 32;              // sine/cosine width
  localparam int PAIR_W  = 2 * SC_W - FRAC; // pair product after floor shift
  localparam int TRIP_W  = PAIR_W + SC_W;
  localparam int SUM_W   = TRIP_W + 1;
  localparam int RND_SH  = 2 * FRAC - (QUAT_WIDTH - 2);
  localparam int RES_W   = SUM_W - RND_SH;

  localparam int HALF_SH = 32 - ANGLE_WIDTH;

  // Merge stages after the lanes: pair, triple, sum
  localparam int MERGE_LAT = 3;
  localparam int LAT       = STEPS + 1 + MERGE_LAT;

  localparam logic signed [CW-1:0] GAIN_INIT = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] HALF_PI_F = CW'(64'sd1686629713);
  localparam logic signed [CW-1:0] PI_F      = CW'(64'sd3373259426);

  localparam logic signed [RES_W-1:0] Q_ONE = RES_W'(1) <<< (QUAT_WIDTH - 2);

  // Sine and cosine of one half angle
  typedef struct packed {
    logic signed [SC_W-1:0] sin_v;
    logic signed [SC_W-1:0] cos_v;
  } sc_t;

  function automatic logic signed [CW-1:0] atan_f(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0:  v = 32'h3243F6A8;  1:  v = 32'h1DAC6705;  2:  v = 32'h0FADBAFC;
        3:  v = 32'h07F56EA6;  4:  v = 32'h03FEAB76;  5:  v = 32'h01FFD55B;
        6:  v = 32'h00FFFAAA;  7:  v = 32'h007FFF55;  8:  v = 32'h003FFFEA;
        9:  v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF;  16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
        18: v = 32'h00000FFF;  19: v = 32'h000007FF;  20: v = 32'h000003FF;
        21: v = 32'h000001FF;  22: v = 32'h000000FF;  23: v = 32'h0000007F;
        24: v = 32'h0000003F;  25: v = 32'h0000001F;  26: v = 32'h0000000F;
        27: v = 32'h00000008;  28: v = 32'h00000004;  29: v = 32'h00000002;
        default: v = 32'h0;
      endcase
      atan_f = $signed({{(CW-32){1'b0}}, v});
    end
  endfunction

endpackage
`default_nettype wire

// File: design/e2q_cordic_lane.sv
// One lane: half angle, range reduction and a pipelined 30-step rotation CORDIC.
`default_nettype none
module e2q_cordic_lane import e2q_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_i,
  output sc_t                                sc_o
);

  logic signed [CW-1:0] half_a;
  logic signed [CW-1:0] z0_d;
  logic                 flip0_d;

  logic signed [CW-1:0] x_q    [STEPS+1];
  logic signed [CW-1:0] y_q    [STEPS+1];
  logic signed [CW-1:0] z_q    [STEPS+1];
  logic                 flip_q [STEPS+1];

  // Exact half angle in Q.30, then fold into +-pi/2
  always_comb begin
    half_a  = CW'(angle_i) <<< HALF_SH;
    z0_d    = half_a;
    flip0_d = 1'b0;
    priority if (half_a > HALF_PI_F) begin
      z0_d    = half_a - PI_F;
      flip0_d = 1'b1;
    end else if (half_a < -HALF_PI_F) begin
      z0_d    = half_a + PI_F;
      flip0_d = 1'b1;
    end else begin
      z0_d    = half_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN_INIT;
      y_q[0]    <= '0;
      z_q[0]    <= z0_d;
      flip_q[0] <= flip0_d;
    end
  end

  // One micro-rotation per stage; the last stage applies the quadrant flip
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] x_d, y_d, z_d;
    always_comb begin
      if (z_q[i] >= 0) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - atan_f(i);
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + atan_f(i);
      end
      if (i == STEPS - 1 && flip_q[i]) begin
        x_d = -x_d;
        y_d = -y_d;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign sc_o.sin_v = y_q[STEPS][SC_W-1:0];
  assign sc_o.cos_v = x_q[STEPS][SC_W-1:0];

endmodule
`default_nettype wire

// File: design/e2q_merge.sv
// Merge stage: pair products, triple products, ZYX sums, rounding and saturation.
`default_nettype none
module e2q_merge import e2q_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire sc_t                          roll_i,
  input  wire sc_t                          pitch_i,
  input  wire sc_t                          yaw_i,
  output logic signed [QUAT_WIDTH-1:0]      q_scalar_o,
  output logic signed [QUAT_WIDTH-1:0]      q_x_o,
  output logic signed [QUAT_WIDTH-1:0]      q_y_o,
  output logic signed [QUAT_WIDTH-1:0]      q_z_o
);

  logic signed [2*SC_W-1:0] m_crcp, m_srsp, m_srcp, m_crsp;
  logic signed [PAIR_W-1:0] crcp_q, srsp_q, srcp_q, crsp_q;
  logic signed [SC_W-1:0]   sy_q, cy_q;
  logic signed [TRIP_W-1:0] t_q [8];
  logic signed [QUAT_WIDTH-1:0] w_d, x_d, y_d, z_d;

  function automatic logic signed [QUAT_WIDTH-1:0] finish_f(
      input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] rs;
    logic signed [RES_W-1:0] r;
    begin
      rs = (s + (SUM_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
      r  = rs[RES_W-1:0];
      if (r > Q_ONE)       r = Q_ONE;
      else if (r < -Q_ONE) r = -Q_ONE;
      finish_f = r[QUAT_WIDTH-1:0];
    end
  endfunction

  // First multiply, floored back to Q.30
  assign m_crcp = roll_i.cos_v * pitch_i.cos_v;
  assign m_srsp = roll_i.sin_v * pitch_i.sin_v;
  assign m_srcp = roll_i.sin_v * pitch_i.cos_v;
  assign m_crsp = roll_i.cos_v * pitch_i.sin_v;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crcp_q <= PAIR_W'(m_crcp >>> FRAC);
      srsp_q <= PAIR_W'(m_srsp >>> FRAC);
      srcp_q <= PAIR_W'(m_srcp >>> FRAC);
      crsp_q <= PAIR_W'(m_crsp >>> FRAC);
      sy_q   <= yaw_i.sin_v;
      cy_q   <= yaw_i.cos_v;
    end
  end

  // Second multiply, Q.60 terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= crcp_q * cy_q;
      t_q[1] <= srsp_q * sy_q;
      t_q[2] <= srcp_q * cy_q;
      t_q[3] <= crsp_q * sy_q;
      t_q[4] <= crsp_q * cy_q;
      t_q[5] <= srcp_q * sy_q;
      t_q[6] <= crcp_q * sy_q;
      t_q[7] <= srsp_q * cy_q;
    end
  end

  // Sums, round half up, saturate
  always_comb begin
    w_d = finish_f(SUM_W'(t_q[0]) + SUM_W'(t_q[1]));
    x_d = finish_f(SUM_W'(t_q[2]) - SUM_W'(t_q[3]));
    y_d = finish_f(SUM_W'(t_q[4]) + SUM_W'(t_q[5]));
    z_d = finish_f(SUM_W'(t_q[6]) - SUM_W'(t_q[7]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_scalar_o <= w_d;
      q_x_o      <= x_d;
      q_y_o      <= y_d;
      q_z_o      <= z_d;
    end
  end

endmodule
`default_nettype wire

// File: design/euler_to_quaternion.sv
// Top level: three CORDIC lanes, the product merge and the valid pipeline.
// Converts roll, pitch and yaw (Q2.13 radians) into a ZYX attitude quaternion
// in Q1.14, saturated to +-1.0. One angle triple is taken per clock unless
// the input is stalled; each result passes one range-reduction stage and
// 30 CORDIC stages in each of the three parallel lanes, then three merge
// stages (pair multiply, triple multiply, sum with rounding). The whole
// pipeline, empty slots included, holds while a finished result is stalled,
// and the input is stalled for those cycles.
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [QUAT_WIDTH-1:0]       q_scalar_o,
  output logic signed [QUAT_WIDTH-1:0]       q_x_o,
  output logic signed [QUAT_WIDTH-1:0]       q_y_o,
  output logic signed [QUAT_WIDTH-1:0]       q_z_o
);

  logic           en;
  logic [LAT-1:0] vld_q, vld_d;
  sc_t            roll_sc, pitch_sc, yaw_sc;

  // Advance unless the finished result is held
  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];
  assign vld_d       = {vld_q[LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  e2q_cordic_lane u_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(roll_angle_i), .sc_o(roll_sc));
  e2q_cordic_lane u_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(pitch_angle_i), .sc_o(pitch_sc));
  e2q_cordic_lane u_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(yaw_angle_i), .sc_o(yaw_sc));

  e2q_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (en),
    .roll_i     (roll_sc),
    .pitch_i    (pitch_sc),
    .yaw_i      (yaw_sc),
    .q_scalar_o (q_scalar_o),
    .q_x_o      (q_x_o),
    .q_y_o      (q_y_o),
    .q_z_o      (q_z_o)
  );

`ifndef SYNTHESIS
  localparam logic signed [QUAT_WIDTH-1:0] QO = QUAT_WIDTH'(1) <<< (QUAT_WIDTH - 2);

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (q_scalar_o <= QO && q_scalar_o >= -QO))
    else $error("q_scalar out of range");
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (q_x_o <= QO && q_x_o >= -QO))
    else $error("q_x out of range");
  a_yz_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (q_y_o <= QO && q_y_o >= -QO && q_z_o <= QO && q_z_o >= -QO))
    else $error("q_y or q_z out of range");
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("valid pipeline moved while output held");
`endif

endmodule
`default_nettype wire

// File: bench/e2q_checker.sv
// Checker for the Euler-to-quaternion block: predicts each quaternion and compares results.
module e2q_checker import e2q_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [QUAT_WIDTH-1:0]  q_scalar_i,
  input  logic signed [QUAT_WIDTH-1:0]  q_x_i,
  input  logic signed [QUAT_WIDTH-1:0]  q_y_i,
  input  logic signed [QUAT_WIDTH-1:0]  q_z_i,
  output int                            err_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] w;
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
  } quat_t;

  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint ARCTAN_Q30 [30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
  };

  quat_t quat_expected[$];
  int    mismatches;
  int    matched;

  // Rotation-mode CORDIC on one half angle, with range folding by pi
  function automatic void half_sin_cos(input logic signed [ANGLE_WIDTH-1:0] ang,
                                       output longint s, output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * (64'sd1 <<< (32 - ANGLE_WIDTH));
    x = CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_Q30[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint prod3(longint a, longint b, longint c);
    return ((a * b) >>> 30) * c;
  endfunction

  // Round half up to Q1.14 and clamp to +-1.0
  function automatic logic signed [QUAT_WIDTH-1:0] to_q14(longint sum);
    longint r, one;
    one = 64'sd1 <<< (QUAT_WIDTH - 2);
    r = (sum + (64'sd1 <<< (60 - (QUAT_WIDTH - 2) - 1))) >>> (60 - (QUAT_WIDTH - 2));
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[QUAT_WIDTH-1:0];
  endfunction

  function automatic quat_t euler_zyx(logic signed [ANGLE_WIDTH-1:0] r_a,
                                      logic signed [ANGLE_WIDTH-1:0] p_a,
                                      logic signed [ANGLE_WIDTH-1:0] y_a);
    longint sr, cr, sp, cp, sy, cy;
    quat_t q;
    half_sin_cos(r_a, sr, cr);
    half_sin_cos(p_a, sp, cp);
    half_sin_cos(y_a, sy, cy);
    q.w = to_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.x = to_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.y = to_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.z = to_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    return q;
  endfunction

  // Watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    quat_t got, want;
    if (!rst_ni) begin
      quat_expected.delete();
      mismatches = 0;
      matched = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        quat_expected.push_back(euler_zyx(roll_angle_i, pitch_angle_i, yaw_angle_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{q_scalar_i, q_x_i, q_y_i, q_z_i};
        if (quat_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result w=%0d x=%0d y=%0d z=%0d",
                     got.w, got.x, got.y, got.z);
        end else begin
          want = quat_expected.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                       want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
          end else begin
            matched++;
          end
        end
      end
    end
  end

  assign err_count_o = mismatches;
  assign pending_o   = quat_expected.size();
  assign checked_o   = matched;

endmodule

// File: bench/tb_top.sv
// Testbench top: drives angle triples into the Euler-to-quaternion block and reports the verdict.
module tb_top;
  import e2q_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [ANGLE_WIDTH-1:0] roll, pitch, yaw;
  logic signed [QUAT_WIDTH-1:0]  qw, qx, qy, qz;
  int err_count, pending, checked;
  int tx_idle_pct, rx_stall_pct;
  bit hold_req;
  int cycles;
  int sent;

  euler_to_quaternion uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .roll_angle_i(roll), .pitch_angle_i(pitch), .yaw_angle_i(yaw),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .q_scalar_o(qw), .q_x_o(qx), .q_y_o(qy), .q_z_o(qz)
  );

  e2q_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .roll_angle_i(roll), .pitch_angle_i(pitch), .yaw_angle_i(yaw),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .q_scalar_i(qw), .q_x_i(qx), .q_y_i(qy), .q_z_i(qz),
    .err_count_o(err_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stall, with an occasional long hold-off on request
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_req && hold_left == 0) begin
      hold_left = 300;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // One transfer; random idle cycles in front of it
  task automatic send_angles(logic signed [ANGLE_WIDTH-1:0] r_a,
                             logic signed [ANGLE_WIDTH-1:0] p_a,
                             logic signed [ANGLE_WIDTH-1:0] y_a);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    roll <= r_a;
    pitch <= p_a;
    yaw <= y_a;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
    sent++;
  endtask

  // Angle near a range-fold boundary (+-pi), an extreme, near zero, or anything
  function automatic logic signed [ANGLE_WIDTH-1:0] pick_angle();
    case ($urandom_range(9))
      0: return 16'sd25736 + 16'($signed($urandom_range(8)) - 4);
      1: return -16'sd25736 + 16'($signed($urandom_range(8)) - 4);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      3: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) send_angles(pick_angle(), pick_angle(), pick_angle());
  endtask

  initial begin
    logic signed [ANGLE_WIDTH-1:0] dir [14];
    cycles = 0;
    sent = 0;
    hold_req = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    in_valid <= 1'b0;
    roll <= '0;
    pitch <= '0;
    yaw <= '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, +-1 LSB, extremes, fold boundaries at +-pi, quarter and eighth turns
    dir = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd25735, 16'sd25736, -16'sd25735,
            -16'sd25736, 16'sd12868, -16'sd12868, 16'sd1, -16'sd1, 16'sd6434,
            16'sd19302, -16'sd19302};
    foreach (dir[i]) send_angles(dir[i], 16'sd0, 16'sd0);
    send_angles(16'sd0, 16'sh7FFF, 16'sd0);
    send_angles(16'sd0, 16'sh8000, 16'sd0);
    send_angles(16'sd0, 16'sd0, 16'sh7FFF);
    send_angles(16'sd0, 16'sd0, 16'sh8000);
    send_angles(16'sd12868, 16'sd12868, 16'sd12868);
    send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sd25736, -16'sd25736, 16'sd25735);

    random_phase(430, 11, 66);
    random_phase(430, 66, 11);
    // Long receiver hold-off while the sender keeps offering
    hold_req = 1;
    random_phase(440, 0, 0);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LAT + 20) @(posedge clk_i);

    $display("Sent %0d angle triples, %0d quaternions matched, with fold boundaries,",
             sent, checked);
    $display("extremes, random stalls on both sides and a long output hold-off.");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
